// ----- hdl/dcc_pkg.sv -----
// Shared types and constants for the graph cursor editor with cycle check.
// Used by the top level; the generic RAM has no package dependency.
package dcc_pkg;

  localparam int ROWS      = 32;          // adjacency rows held
  localparam int ROW_W     = 32;          // parent bits per row
  localparam int IDX_W     = 5;           // row / column index width
  localparam int CNT_W     = 6;           // node count width
  localparam int MAX_NODES_DEF = 32;
  localparam logic [CNT_W-1:0] NODE_COUNT_RST = 6'd32;
  localparam logic [CNT_W-1:0] MIN_NODES      = 6'd2;

  localparam logic [1:0] CMD_STEP  = 2'd0;
  localparam logic [1:0] CMD_ROW   = 2'd1;
  localparam logic [1:0] CMD_PLACE = 2'd2;

  localparam logic [2:0] MV_LEFT  = 3'd1;
  localparam logic [2:0] MV_RIGHT = 3'd2;
  localparam logic [2:0] MV_UP    = 3'd3;
  localparam logic [2:0] MV_DOWN  = 3'd4;

  localparam logic [1:0] ARC_ADD = 2'd1;
  localparam logic [1:0] ARC_DEL = 2'd2;

  typedef struct packed {
    logic [1:0]       command;
    logic [2:0]       move;
    logic [1:0]       arc_op;
    logic [IDX_W-1:0] row_index;
    logic [ROW_W-1:0] row_bits;
    logic [IDX_W-1:0] set_row;
    logic [IDX_W-1:0] set_col;
  } in_item_t;

  typedef struct packed {
    logic [IDX_W-1:0] cursor_row;
    logic [IDX_W-1:0] cursor_col;
    logic             rejected;
    logic             arc_at_cursor;
  } out_item_t;

endpackage

// ----- hdl/dcc_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module dcc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- hdl/dag_cursor_edit_with_cycle_check_core.sv -----
// Graph cursor editor: adjacency matrix in one RAM, cursor moves, arc edits, Kahn cycle check.
// Load commands: fetch, then output. Step: row read, edit write, 1 .. n peeling sweeps (n =
// board size), undo on reject, fetch, output; each sweep reads one adjacency row per cycle
// through the single RAM read port. One transaction in flight; output register frees the input.
// Synchronous active-low reset: empty graph (per-row valid bits), cursor 0, node_count 32.
// Depends on dcc_pkg and dcc_ram.
module dag_cursor_edit_with_cycle_check_core
  import dcc_pkg::*;
#(
  parameter int MAX_NODES = MAX_NODES_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  in_item_t         in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output out_item_t        out_data,
  input  logic             cfg_we,
  input  logic [CNT_W-1:0] cfg_wdata
);

  localparam int BOARD_LIM_I = (MAX_NODES < ROWS) ? MAX_NODES : ROWS;
  localparam logic [CNT_W-1:0] BOARD_LIM = CNT_W'(BOARD_LIM_I);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_EDIT  = 6'b000010,
    S_PEEL  = 6'b000100,
    S_UNDO  = 6'b001000,
    S_FETCH = 6'b010000,
    S_OUT   = 6'b100000
  } state_t;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] node_count_r, node_count_nxt;
  logic [IDX_W-1:0] cur_row_r, cur_row_nxt, cur_col_r, cur_col_nxt;
  logic [IDX_W-1:0] tgt_row_r, tgt_row_nxt, tgt_col_r, tgt_col_nxt;
  logic [1:0]       arc_op_r, arc_op_nxt;
  logic [ROW_W-1:0] saved_r, saved_nxt;
  logic [ROW_W-1:0] act_r, act_nxt;
  logic             iss_en_r, iss_en_nxt, chk_en_r, chk_en_nxt;
  logic [IDX_W-1:0] iss_idx_r, iss_idx_nxt, chk_idx_r, chk_idx_nxt;
  logic             drop_any_r, drop_any_nxt;
  logic             rejected_r, rejected_nxt;
  logic [ROWS-1:0]  vld_r;
  logic             rd_vld_r;
  logic             out_valid_r, out_valid_nxt;
  out_item_t        out_data_r, out_data_nxt;

  logic             ram_we, ram_re;
  logic [IDX_W-1:0] ram_waddr, ram_raddr;
  logic [ROW_W-1:0] ram_wdata, ram_rdata;

  logic [CNT_W-1:0] board_n;
  logic [IDX_W-1:0] last_idx;
  logic [ROW_W-1:0] board_mask;
  logic [ROW_W-1:0] row_eff;
  logic [ROW_W-1:0] edited;
  logic [ROW_W-1:0] act_after;
  logic             drop;
  logic [IDX_W-1:0] mv_row, mv_col;

  dcc_ram #(
    .WIDTH (ROW_W),
    .DEPTH (ROWS)
  ) u_adj_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // board size clamped to MIN_NODES .. BOARD_LIM
  always_comb begin
    board_n = node_count_r;
    if (board_n < MIN_NODES) begin
      board_n = MIN_NODES;
    end else if (board_n > BOARD_LIM) begin
      board_n = BOARD_LIM;
    end
  end

  assign last_idx   = IDX_W'(board_n - 6'd1);
  assign board_mask = ~({ROW_W{1'b1}} << board_n);
  // rows never written read as empty
  assign row_eff    = rd_vld_r ? ram_rdata : '0;

  // cursor move candidate for a step
  always_comb begin
    mv_row = cur_row_r;
    mv_col = cur_col_r;
    if (in_data.move == MV_LEFT) begin
      if (cur_col_r != '0) mv_col = cur_col_r - 5'd1;
    end else if (in_data.move == MV_RIGHT) begin
      if (({1'b0, cur_col_r} + 6'd1) < board_n) mv_col = cur_col_r + 5'd1;
    end else if (in_data.move == MV_UP) begin
      if (cur_row_r != '0) mv_row = cur_row_r - 5'd1;
    end else if (in_data.move == MV_DOWN) begin
      if (({1'b0, cur_row_r} + 6'd1) < board_n) mv_row = cur_row_r + 5'd1;
    end
  end

  always_comb begin
    edited = row_eff;
    if (arc_op_r == ARC_ADD) begin
      edited[tgt_col_r] = 1'b1;
    end else if (arc_op_r == ARC_DEL) begin
      edited[tgt_col_r] = 1'b0;
    end
  end

  // peel check on the row returned this cycle
  always_comb begin
    drop      = chk_en_r && act_r[chk_idx_r] && ((row_eff & act_r) == '0);
    act_after = act_r;
    if (drop) act_after[chk_idx_r] = 1'b0;
  end

  always_comb begin
    state_nxt      = state_r;
    node_count_nxt = cfg_we ? cfg_wdata : node_count_r;
    cur_row_nxt    = cur_row_r;
    cur_col_nxt    = cur_col_r;
    tgt_row_nxt    = tgt_row_r;
    tgt_col_nxt    = tgt_col_r;
    arc_op_nxt     = arc_op_r;
    saved_nxt      = saved_r;
    act_nxt        = act_r;
    iss_en_nxt     = iss_en_r;
    iss_idx_nxt    = iss_idx_r;
    chk_en_nxt     = 1'b0;
    chk_idx_nxt    = chk_idx_r;
    drop_any_nxt   = drop_any_r;
    rejected_nxt   = rejected_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_data_nxt   = out_data_r;
    ram_we         = 1'b0;
    ram_waddr      = tgt_row_r;
    ram_wdata      = edited;
    ram_re         = 1'b0;
    ram_raddr      = cur_row_r;
    in_ready       = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          rejected_nxt = 1'b0;
          state_nxt    = S_FETCH;
          unique case (in_data.command)
            CMD_STEP: begin
              tgt_row_nxt = mv_row;
              tgt_col_nxt = mv_col;
              arc_op_nxt  = in_data.arc_op;
              ram_re      = 1'b1;
              ram_raddr   = mv_row;
              state_nxt   = S_EDIT;
            end
            CMD_ROW: begin
              ram_we    = 1'b1;
              ram_waddr = in_data.row_index;
              ram_wdata = in_data.row_bits;
            end
            CMD_PLACE: begin
              cur_row_nxt = in_data.set_row;
              cur_col_nxt = in_data.set_col;
            end
            default: ;
          endcase
        end
      end
      S_EDIT: begin
        saved_nxt    = row_eff;
        ram_we       = 1'b1;
        act_nxt      = board_mask;
        iss_en_nxt   = 1'b1;
        iss_idx_nxt  = '0;
        drop_any_nxt = 1'b0;
        state_nxt    = S_PEEL;
      end
      S_PEEL: begin
        ram_re       = iss_en_r;
        ram_raddr    = iss_idx_r;
        chk_en_nxt   = iss_en_r;
        chk_idx_nxt  = iss_idx_r;
        if (iss_en_r) begin
          if (iss_idx_r == last_idx) iss_en_nxt = 1'b0;
          else iss_idx_nxt = iss_idx_r + 5'd1;
        end
        act_nxt      = act_after;
        drop_any_nxt = drop_any_r | drop;
        // end of a sweep
        if (chk_en_r && chk_idx_r == last_idx) begin
          if (act_after == '0) begin
            cur_row_nxt = tgt_row_r;
            cur_col_nxt = tgt_col_r;
            state_nxt   = S_FETCH;
          end else if (drop_any_r || drop) begin
            iss_en_nxt   = 1'b1;
            iss_idx_nxt  = '0;
            drop_any_nxt = 1'b0;
          end else begin
            rejected_nxt = 1'b1;
            state_nxt    = S_UNDO;
          end
        end
      end
      S_UNDO: begin
        ram_we    = 1'b1;
        ram_wdata = saved_r;
        state_nxt = S_FETCH;
      end
      S_FETCH: begin
        ram_re    = 1'b1;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt              = 1'b1;
          out_data_nxt.cursor_row    = cur_row_r;
          out_data_nxt.cursor_col    = cur_col_r;
          out_data_nxt.rejected      = rejected_r;
          out_data_nxt.arc_at_cursor = row_eff[cur_col_r];
          state_nxt                  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      node_count_r <= NODE_COUNT_RST;
      cur_row_r    <= '0;
      cur_col_r    <= '0;
      act_r        <= '0;
      iss_en_r     <= 1'b0;
      chk_en_r     <= 1'b0;
      drop_any_r   <= 1'b0;
      rejected_r   <= 1'b0;
      vld_r        <= '0;
      rd_vld_r     <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      node_count_r <= node_count_nxt;
      cur_row_r    <= cur_row_nxt;
      cur_col_r    <= cur_col_nxt;
      act_r        <= act_nxt;
      iss_en_r     <= iss_en_nxt;
      chk_en_r     <= chk_en_nxt;
      drop_any_r   <= drop_any_nxt;
      rejected_r   <= rejected_nxt;
      out_valid_r  <= out_valid_nxt;
      if (ram_we) vld_r[ram_waddr] <= 1'b1;
      if (ram_re) rd_vld_r <= vld_r[ram_raddr];
    end
  end

  always_ff @(posedge clk) begin
    tgt_row_r  <= tgt_row_nxt;
    tgt_col_r  <= tgt_col_nxt;
    arc_op_r   <= arc_op_nxt;
    saved_r    <= saved_nxt;
    iss_idx_r  <= iss_idx_nxt;
    chk_idx_r  <= chk_idx_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_act_in_board: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_PEEL) |-> ((act_r & ~board_mask) == '0))
    else $error("peel mask holds nodes outside the board");

  a_undo_cause: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_UNDO) |-> (rejected_r && act_r != '0))
    else $error("undo without surviving nodes");

  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second transaction accepted while one is in work");

  a_check_in_peel: assert property (@(posedge clk) disable iff (!rst_n)
    chk_en_r |-> (state_r == S_PEEL))
    else $error("row check outside peeling");

endmodule
